[rtl/core/kcbg_pkg.sv]
package kcbg_pkg;

  // Data path widths.
  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int SHARD_W = 32;
  localparam int LEN_W   = 4;
  localparam int LANE_W  = 3;
  localparam int BYTES   = 8;

  // Valid and sideband stages ahead of the output register.
  localparam int LINE_LEN = 8;

  // Mixing constants.
  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] INDEX_MUL    = 64'hD1B5_4A32_D192_ED03;
  localparam logic [7:0]        BYTE_MASK    = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STREAM_SEED  = 2'd0,
    REG_SHARD_NUMBER = 2'd1
  } cfg_reg_t;

  // Per-transaction control that travels beside the mixing pipeline.
  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] first_byte;
    logic [LEN_W-1:0]  count;
  } side_t;

endpackage

[rtl/core/keyed_counter_byte_generator.sv]
// Throughput: one transaction per cycle, with no gaps; busy is high only during reset.
// Depth: three chained 64-bit multiplies of two stages each, two shift-xor stages
// and the output register.
// Reset clears both configuration registers to zero and empties the pipeline.
// Results appear for one cycle under result_valid; the receiver cannot stall them.
module keyed_counter_byte_generator import kcbg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] byte_offset,
  input  logic [LEN_W-1:0]  request_length,
  input  logic              write_enable,
  input  logic [1:0]        register_index,
  input  logic [WORD_W-1:0] write_data,
  output logic              result_valid,
  output logic [WORD_W-1:0] data_word,
  output logic [LEN_W-1:0]  byte_count
);

  logic [WORD_W-1:0]  stream_seed;
  logic [SHARD_W-1:0] shard_number;
  logic               accept;
  logic [LEN_W-1:0]   avail;
  logic [LEN_W-1:0]   count;
  logic [WORD_W-1:0]  counter_index;
  logic [LINE_LEN-1:0] valid_line;
  logic [LANE_W-1:0]  lane_line [LINE_LEN];
  logic [LEN_W-1:0]   count_line [LINE_LEN];
  logic [WORD_W-1:0]  seed_d0;
  logic [WORD_W-1:0]  seed_d1;
  logic [WORD_W-1:0]  index_prod;
  logic [WORD_W-1:0]  shard_prod;
  logic [WORD_W-1:0]  mix_in;
  logic [WORD_W-1:0]  z0;
  logic [WORD_W-1:0]  z1;
  logic [WORD_W-1:0]  z2;
  logic [WORD_W-1:0]  z2x;
  logic [WORD_W-1:0]  z3;
  side_t              side;

  // The pipeline takes a transaction every cycle outside reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_seed  <= '0;
      shard_number <= '0;
    end else if (write_enable) begin
      case (cfg_reg_t'(register_index))
        REG_STREAM_SEED:  stream_seed  <= write_data;
        REG_SHARD_NUMBER: shard_number <= write_data[SHARD_W-1:0];
        default: ;
      endcase
    end
  end

  // Bytes delivered: the request, clipped at the end of the word.
  assign avail = LEN_W'(BYTES) - {1'b0, byte_offset[LANE_W-1:0]};
  assign count = (request_length < avail) ? request_length : avail;

  assign counter_index = {{LANE_W{1'b0}}, byte_offset[WORD_W-1:LANE_W]};

  // Valid bits beside the mixing stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_line <= '0;
    end else begin
      valid_line <= {valid_line[LINE_LEN-2:0], accept};
    end
  end

  // Byte lane and count travel with the transaction.
  always_ff @(posedge clk) begin
    lane_line[0]  <= byte_offset[LANE_W-1:0];
    count_line[0] <= count;
    for (int k = 1; k < LINE_LEN; k++) begin
      lane_line[k]  <= lane_line[k-1];
      count_line[k] <= count_line[k-1];
    end
  end

  // Seed is delayed to meet the key product.
  always_ff @(posedge clk) begin
    seed_d0 <= stream_seed;
    seed_d1 <= seed_d0;
  end

  // Word index times its multiplier, and the shard's key contribution.
  kcbg_mul_lo u_index_mul (
    .clk     (clk),
    .a       (counter_index),
    .b       (INDEX_MUL),
    .product (index_prod)
  );

  kcbg_mul_lo u_shard_mul (
    .clk     (clk),
    .a       ({{(WORD_W-SHARD_W){1'b0}}, shard_number}),
    .b       (GOLDEN_GAMMA),
    .product (shard_prod)
  );

  // Combine key and counter, add gamma and take the first shift-xor.
  assign mix_in = seed_d1 ^ shard_prod ^ index_prod;
  assign z0     = mix_in + GOLDEN_GAMMA;

  always_ff @(posedge clk) begin
    z1 <= z0 ^ (z0 >> 30);
  end

  kcbg_mul_lo u_mix_mul_a (
    .clk     (clk),
    .a       (z1),
    .b       (MIX_MUL_A),
    .product (z2)
  );

  always_ff @(posedge clk) begin
    z2x <= z2 ^ (z2 >> 27);
  end

  kcbg_mul_lo u_mix_mul_b (
    .clk     (clk),
    .a       (z2x),
    .b       (MIX_MUL_B),
    .product (z3)
  );

  // Byte selection and output register.
  assign side = '{valid: valid_line[LINE_LEN-1],
                  first_byte: lane_line[LINE_LEN-1],
                  count: count_line[LINE_LEN-1]};

  kcbg_select u_select (
    .clk          (clk),
    .rst          (rst),
    .side         (side),
    .mix_word     (z3),
    .result_valid (result_valid),
    .data_word    (data_word),
    .byte_count   (byte_count)
  );

  // Every accepted transaction gives exactly one result, a fixed time later.
  assert property (@(posedge clk) disable iff (rst)
    result_valid == $past(start && !busy, LINE_LEN + 1))
    else $error("result strobe does not follow the accepted transaction");

  // Never more than one word of bytes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_count <= LEN_W'(BYTES))
    else $error("byte count exceeds a word");

  // Bytes above the delivered count are zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_count < LEN_W'(BYTES)) |->
      (data_word >> {byte_count, 3'b000}) == '0)
    else $error("bytes above the count are not zero");

endmodule

[rtl/core/kcbg_mul_lo.sv]
module kcbg_mul_lo import kcbg_pkg::*; (
  input  logic              clk,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] product
);

  logic [WORD_W-1:0] ll_full;
  logic [WORD_W-1:0] lh_full;
  logic [WORD_W-1:0] hl_full;
  logic [WORD_W-1:0] ll;
  logic [HALF_W-1:0] lh;
  logic [HALF_W-1:0] hl;
  logic [HALF_W-1:0] cross_sum;

  // Three 32 by 32 partial products; the high-by-high term falls outside 64 bits.
  assign ll_full = WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
  assign lh_full = WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[WORD_W-1:HALF_W]);
  assign hl_full = WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);

  always_ff @(posedge clk) begin
    ll <= ll_full;
    lh <= lh_full[HALF_W-1:0];
    hl <= hl_full[HALF_W-1:0];
  end

  // The cross terms only reach the upper half of the result.
  assign cross_sum = lh + hl;

  always_ff @(posedge clk) begin
    product <= ll + {cross_sum, {HALF_W{1'b0}}};
  end

endmodule

[rtl/core/kcbg_select.sv]
module kcbg_select import kcbg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  side_t             side,
  input  logic [WORD_W-1:0] mix_word,
  output logic              result_valid,
  output logic [WORD_W-1:0] data_word,
  output logic [LEN_W-1:0]  byte_count
);

  logic [WORD_W-1:0] final_word;
  logic [WORD_W-1:0] shifted;
  logic [WORD_W-1:0] packed_bytes;

  // Last finalizer step, then move the first wanted byte down to bit 0.
  assign final_word = mix_word ^ (mix_word >> 31);
  assign shifted    = final_word >> {side.first_byte, 3'b000};

  // Keep only the bytes below the delivered count.
  always_comb begin
    packed_bytes = '0;
    for (int i = 0; i < BYTES; i++) begin
      if (LEN_W'(i) < side.count) begin
        packed_bytes[8*i +: 8] = shifted[8*i +: 8] & BYTE_MASK;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= side.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    data_word  <= packed_bytes;
    byte_count <= side.count;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import kcbg_pkg::*;

  // Register indexes that decode to nothing; writes to them must be ignored.
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int QUIET_CYCLES    = LINE_LEN + 4;

  // One expected chunk of generated content.
  typedef struct {
    logic [WORD_W-1:0] data;
    logic [LEN_W-1:0]  count;
  } stream_chunk_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [WORD_W-1:0] byte_offset;
  logic [LEN_W-1:0]  request_length;
  logic              write_enable;
  logic [1:0]        register_index;
  logic [WORD_W-1:0] write_data;
  logic              result_valid;
  logic [WORD_W-1:0] data_word;
  logic [LEN_W-1:0]  byte_count;

  // Local copy of the configuration registers.
  logic [WORD_W-1:0]  seed_copy;
  logic [SHARD_W-1:0] shard_copy;

  stream_chunk_t pending_chunks[$];
  bit pace_gaps;
  int error_count;
  int requests_sent;
  int chunks_checked;
  int config_writes;

  keyed_counter_byte_generator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .byte_offset    (byte_offset),
    .request_length (request_length),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .result_valid   (result_valid),
    .data_word      (data_word),
    .byte_count     (byte_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scrambles one word through the splitmix64 finalizer.
  function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] z;
    z = v + GOLDEN_GAMMA;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // Computes the bytes the generator owes for one request under the current key.
  function automatic stream_chunk_t predict_chunk(input logic [WORD_W-1:0] offset,
                                                  input logic [LEN_W-1:0]  length);
    stream_chunk_t chunk;
    logic [WORD_W-1:0] stream_key;
    logic [WORD_W-1:0] counter_index;
    logic [WORD_W-1:0] mixed;
    int lane;
    int lanes_left;
    int count;
    stream_key    = seed_copy ^ ({32'd0, shard_copy} * GOLDEN_GAMMA);
    counter_index = offset >> 3;
    mixed         = scramble_word(stream_key ^ (counter_index * INDEX_MUL));
    lane          = offset[LANE_W-1:0];
    lanes_left    = BYTES - lane;
    count         = (length < lanes_left) ? length : lanes_left;
    chunk.data = '0;
    for (int i = 0; i < count; i++) begin
      chunk.data[8*i +: 8] = mixed[8*(lane+i) +: 8] & BYTE_MASK;
    end
    chunk.count = count[LEN_W-1:0];
    return chunk;
  endfunction

  // Mostly legal lengths, with zero and oversized lengths mixed in.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) begin
      return LEN_W'($urandom_range(1, 8));
    end else if (r == 12) begin
      return '0;
    end
    return LEN_W'($urandom_range(9, 15));
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Offers one request and returns right after the edge that accepts it.
  task automatic send_request(input logic [WORD_W-1:0] offset,
                              input logic [LEN_W-1:0]  length);
    int gap;
    bit taken;
    gap = pace_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start          <= 1'b0;
      byte_offset    <= {$urandom, $urandom};
      request_length <= LEN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    byte_offset    <= offset;
    request_length <= length;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (busy === 1'b0) begin
        taken = 1'b1;
        pending_chunks.insert(pending_chunks.size(), predict_chunk(offset, length));
        requests_sent++;
      end
      @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every expected transaction has come back.
  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_register(input logic [1:0] index, input logic [WORD_W-1:0] value);
    write_enable   <= 1'b1;
    register_index <= index;
    write_data     <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    case (index)
      REG_STREAM_SEED:  seed_copy = value;
      REG_SHARD_NUMBER: shard_copy = value[SHARD_W-1:0];
      default: ;
    endcase
    config_writes++;
    @(posedge clk);
  endtask

  // Compares every result against the oldest outstanding expectation.
  always @(negedge clk) begin
    stream_chunk_t want;
    if (rst === 1'b0 && result_valid === 1'b1) begin
      if (pending_chunks.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: data %h count %0d",
                                  data_word, byte_count));
      end else begin
        want = pending_chunks.pop_front();
        chunks_checked++;
        if (data_word !== want.data) begin
          report_mismatch($sformatf("data_word %h, expected %h", data_word, want.data));
        end
        if (byte_count !== want.count) begin
          report_mismatch($sformatf("byte_count %0d, expected %0d", byte_count, want.count));
        end
      end
    end
  end

  // Both registers must come out of reset as zero.
  task automatic test_reset_defaults();
    send_request('0, LEN_W'(8));
    send_request(WORD_W'(8), LEN_W'(8));
  endtask

  // Field extremes, zero and oversized lengths, every byte lane and offset wrap.
  task automatic test_directed_edges();
    send_request('0, '0);
    for (int lane = 0; lane < BYTES; lane++) begin
      send_request(WORD_W'(8 * (lane + 3) + lane), LEN_W'(8));
    end
    send_request('1, LEN_W'(1));
    send_request('1, LEN_W'(15));
    send_request(64'hFFFF_FFFF_FFFF_FFF8, LEN_W'(8));
    send_request(WORD_W'(5), LEN_W'(9));
    send_request(WORD_W'(3), LEN_W'(15));
    send_request(64'h8000_0000_0000_0000, LEN_W'(4));
    send_request(WORD_W'(2), LEN_W'(3));
  endtask

  // Register extremes, truncation of the shard field and unused indexes.
  task automatic test_register_writes();
    wait_for_quiet();
    write_register(REG_STREAM_SEED, '1);
    write_register(REG_SHARD_NUMBER, '1);
    send_request(64'h0123_4567_89AB_CDE9, LEN_W'(8));
    wait_for_quiet();
    write_register(REG_STREAM_SEED, '0);
    write_register(REG_SHARD_NUMBER, 64'hFFFF_FFFF_0000_0001);
    send_request(WORD_W'(16), LEN_W'(8));
    wait_for_quiet();
    write_register(REG_SPARE_2, '1);
    write_register(REG_SPARE_3, 64'hA5A5_5A5A_A5A5_5A5A);
    send_request(WORD_W'(16), LEN_W'(8));
    send_request(WORD_W'(21), LEN_W'(2));
  endtask

  // Phases of random traffic, mostly contiguous reads through a stream.
  task automatic test_random_traffic();
    logic [WORD_W-1:0] cursor;
    logic [WORD_W-1:0] offset;
    logic [LEN_W-1:0]  length;
    int kind;
    int lanes_left;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_quiet();
      case (phase)
        0: begin
          write_register(REG_STREAM_SEED, '0);
          write_register(REG_SHARD_NUMBER, '0);
        end
        1: begin
          write_register(REG_STREAM_SEED, '1);
          write_register(REG_SHARD_NUMBER, '1);
        end
        2: begin
          write_register(REG_STREAM_SEED, '0);
          write_register(REG_SHARD_NUMBER, '1);
        end
        3: begin
          write_register(REG_STREAM_SEED, '1);
          write_register(REG_SHARD_NUMBER, '0);
        end
        default: begin
          write_register(REG_STREAM_SEED, {$urandom, $urandom});
          write_register(REG_SHARD_NUMBER, {$urandom, $urandom});
          write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         {$urandom, $urandom});
        end
      endcase
      // Some streams start near the top of the offset space so that they wrap.
      cursor = (phase % 3 == 1) ? 64'hFFFF_FFFF_FFFF_FF00 - $urandom_range(0, 15)
                                : {$urandom, $urandom};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) pace_gaps = ($urandom_range(0, 2) != 0);
        kind   = $urandom_range(0, 9);
        length = pick_length();
        if (kind <= 5) begin
          offset = cursor;
        end else if (kind <= 7) begin
          offset = {$urandom, $urandom};
        end else if (kind == 8) begin
          offset = '1 - $urandom_range(0, 31);
        end else begin
          offset = WORD_W'($urandom_range(0, 63));
        end
        send_request(offset, length);
        if (kind <= 5) begin
          lanes_left = BYTES - offset[LANE_W-1:0];
          cursor = offset + ((length < lanes_left) ? length : lanes_left);
          if ($urandom_range(0, 63) == 0) cursor = {$urandom, $urandom};
        end
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    byte_offset    <= '0;
    request_length <= '0;
    write_enable   <= 1'b0;
    register_index <= REG_STREAM_SEED;
    write_data     <= '0;
    seed_copy   = '0;
    shard_copy  = '0;
    pace_gaps   = 1'b1;
    error_count = 0;
    requests_sent  = 0;
    chunks_checked = 0;
    config_writes  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_edges();
    test_register_writes();
    test_random_traffic();
    wait_for_quiet();

    $display("Covered %0d requests and %0d checked results over %0d register writes,",
             requests_sent, chunks_checked, config_writes);
    $display("including zero and oversized lengths, all byte lanes and offset wrap.");
    if (error_count == 0 && pending_chunks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs or drops a transaction.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_chunks.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
